// File: src/grid_restrict_3d_factor2_core_macros.svh
// Assertion macros shared by the restriction core.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef GRID_RESTRICT_3D_FACTOR2_CORE_MACROS_SVH
`define GRID_RESTRICT_3D_FACTOR2_CORE_MACROS_SVH

// Property checked every clock outside reset
`define GR3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define GR3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gr3d_pkg.sv
`timescale 1ns / 1ps
package gr3d_pkg;

  localparam int DEF_MAX_EXTENT  = 256;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int CFG_W           = 9;   // widest configuration register
  localparam int CFG_IDX_W       = 3;
  localparam int IDX_W           = 8;   // coarse index ports
  localparam int QUEUE_DEPTH     = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_I = 3'd0,
    REG_EXTENT_J = 3'd1,
    REG_EXTENT_K = 3'd2,
    REG_CELL_I   = 3'd3,
    REG_CELL_J   = 3'd4,
    REG_CELL_K   = 3'd5
  } gr3d_reg_e;

  // Per-sample control handed from the front to the back
  typedef struct packed {
    logic       odd_i;
    logic       odd_j;
    logic       odd_k;
    logic       last_i;
    logic       last_j;
    logic       last_k;
    logic       done;
    logic [1:0] shift;   // number of cell-centered axes
  } gr3d_ctrl_t;

  localparam int CTRL_W = $bits(gr3d_ctrl_t);

endpackage

// File: src/grid_restrict_3d_factor2_core.sv
`timescale 1ns / 1ps
// 3-D factor-two restriction: fine samples stream in raster order (i fastest) and one
// coarse value leaves per group, injected on vertex-centered axes and averaged with
// floor rounding on cell-centered ones; the sums are kept wide, so nothing saturates.
// The block takes one fine sample every clock unless the queue is full. A front stage
// tracks the fine position and classifies each sample; samples that contribute go
// through a four-entry queue to a three-stage back end (pair sum, row buffer, plane
// buffer). A result leaves the queue head through the stage B, stage C and output
// registers in turn. The row and plane buffers are single memories with registered
// reads and a bypass for back-to-back hits on the same entry; every entry is written
// in a region before it is read, so there is no clearing pass after reset. Input
// ready drops only when the queue fills while a result waits at the output. A write
// to any of the six configuration registers restarts the region; write it only while
// the block is idle.
module grid_restrict_3d_factor2_core #(
  parameter int MAX_EXTENT  = gr3d_pkg::DEF_MAX_EXTENT,
  parameter int SAMPLE_BITS = gr3d_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gr3d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gr3d_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   fine_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   coarse_value_o,
  output logic [gr3d_pkg::IDX_W-1:0]      coarse_i_o,
  output logic [gr3d_pkg::IDX_W-1:0]      coarse_j_o,
  output logic [gr3d_pkg::IDX_W-1:0]      coarse_k_o,
  output logic                            region_done_o
);
  import gr3d_pkg::*;

  localparam int CI_W = $clog2(MAX_EXTENT);
  localparam int QW   = CTRL_W + 3 * CI_W + SAMPLE_BITS;

  logic                          push, full, pop, empty;
  gr3d_ctrl_t                    f_ctrl, h_ctrl;
  logic [CI_W-1:0]               f_ci, f_cj, f_ck, h_ci, h_cj, h_ck;
  logic signed [SAMPLE_BITS-1:0] f_sample, h_sample;
  logic [QW-1:0]                 q_wdata, q_rdata;

  gr3d_front #(
    .MAX_EXTENT (MAX_EXTENT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .fine_sample_i(fine_sample_i),
    .full_i       (full),
    .push_o       (push),
    .ctrl_o       (f_ctrl),
    .ci_o         (f_ci),
    .cj_o         (f_cj),
    .ck_o         (f_ck),
    .sample_o     (f_sample)
  );

  // Queue entry: control, coarse indices, sample
  assign q_wdata = {f_ctrl, f_ci, f_cj, f_ck, f_sample};
  assign {h_ctrl, h_ci, h_cj, h_ck, h_sample} = q_rdata;

  gr3d_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(q_rdata)
  );

  gr3d_back #(
    .MAX_EXTENT (MAX_EXTENT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (!empty),
    .pop_o         (pop),
    .ctrl_i        (h_ctrl),
    .ci_i          (h_ci),
    .cj_i          (h_cj),
    .ck_i          (h_ck),
    .sample_i      (h_sample),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coarse_value_o(coarse_value_o),
    .coarse_i_o    (coarse_i_o),
    .coarse_j_o    (coarse_j_o),
    .coarse_k_o    (coarse_k_o),
    .region_done_o (region_done_o)
  );

endmodule

// File: src/gr3d_front.sv
`timescale 1ns / 1ps
module gr3d_front #(
  parameter int MAX_EXTENT  = 256,
  parameter int SAMPLE_BITS = 32,
  localparam int CI_W = $clog2(MAX_EXTENT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gr3d_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gr3d_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       fine_sample_i,
  input  logic                                full_i,
  output logic                                push_o,
  output gr3d_pkg::gr3d_ctrl_t                ctrl_o,
  output logic [CI_W-1:0]                     ci_o,
  output logic [CI_W-1:0]                     cj_o,
  output logic [CI_W-1:0]                     ck_o,
  output logic signed [SAMPLE_BITS-1:0]       sample_o
);
  import gr3d_pkg::*;

  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int CMP_W = (EXT_W > CFG_W) ? EXT_W : CFG_W;
  localparam int POS_W = EXT_W + 1;

  logic [CFG_W-1:0] ext_i_q, ext_j_q, ext_k_q;
  logic             cc_i_q, cc_j_q, cc_k_q;
  logic [POS_W-1:0] pos_i_q, pos_j_q, pos_k_q;
  logic [POS_W-1:0] pos_i_d, pos_j_d, pos_k_d;
  logic [EXT_W-1:0] ei, ej, ek;
  logic [POS_W-1:0] end_i, end_j, end_k;
  logic             accept, take, restart;

  // Clamp an extent to 1..MAX_EXTENT
  function automatic logic [EXT_W-1:0] eff_ext(input logic [CFG_W-1:0] e);
    logic [CMP_W-1:0] ew;
    ew = CMP_W'(e);
    if (ew == '0) return EXT_W'(1);
    else if (ew > CMP_W'(MAX_EXTENT)) return EXT_W'(MAX_EXTENT);
    else return EXT_W'(ew);
  endfunction

  assign ei = eff_ext(ext_i_q);
  assign ej = eff_ext(ext_j_q);
  assign ek = eff_ext(ext_k_q);

  // Last fine position per axis: 2E-2, plus one on a cell-centered axis
  assign end_i = {ei, 1'b0} - POS_W'(2) + POS_W'(cc_i_q);
  assign end_j = {ej, 1'b0} - POS_W'(2) + POS_W'(cc_j_q);
  assign end_k = {ek, 1'b0} - POS_W'(2) + POS_W'(cc_k_q);

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the current position
  assign take = (cc_i_q || !pos_i_q[0]) && (cc_j_q || !pos_j_q[0]) &&
                (cc_k_q || !pos_k_q[0]);
  assign push_o = accept && take;

  assign ci_o = pos_i_q[CI_W:1];
  assign cj_o = pos_j_q[CI_W:1];
  assign ck_o = pos_k_q[CI_W:1];
  assign sample_o = fine_sample_i;

  always_comb begin
    ctrl_o.odd_i  = pos_i_q[0];
    ctrl_o.odd_j  = pos_j_q[0];
    ctrl_o.odd_k  = pos_k_q[0];
    ctrl_o.last_i = cc_i_q ? pos_i_q[0] : 1'b1;
    ctrl_o.last_j = cc_j_q ? pos_j_q[0] : 1'b1;
    ctrl_o.last_k = cc_k_q ? pos_k_q[0] : 1'b1;
    ctrl_o.done   = (ci_o == CI_W'(ei - EXT_W'(1))) &&
                    (cj_o == CI_W'(ej - EXT_W'(1))) &&
                    (ck_o == CI_W'(ek - EXT_W'(1)));
    ctrl_o.shift  = {1'b0, cc_i_q} + {1'b0, cc_j_q} + {1'b0, cc_k_q};
  end

  // Raster position stepping, i fastest
  always_comb begin
    pos_i_d = pos_i_q;
    pos_j_d = pos_j_q;
    pos_k_d = pos_k_q;
    if (accept) begin
      if (pos_i_q == end_i) begin
        pos_i_d = '0;
        if (pos_j_q == end_j) begin
          pos_j_d = '0;
          pos_k_d = (pos_k_q == end_k) ? '0 : pos_k_q + POS_W'(1);
        end else begin
          pos_j_d = pos_j_q + POS_W'(1);
        end
      end else begin
        pos_i_d = pos_i_q + POS_W'(1);
      end
    end
  end

  // Any write to a known register restarts the region
  always_comb begin
    case (gr3d_reg_e'(cfg_idx_i))
      REG_EXTENT_I, REG_EXTENT_J, REG_EXTENT_K,
      REG_CELL_I, REG_CELL_J, REG_CELL_K: restart = cfg_we_i;
      default:                            restart = 1'b0;
    endcase
  end

  // Configuration registers and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_i_q <= CFG_W'(1);
      ext_j_q <= CFG_W'(1);
      ext_k_q <= CFG_W'(1);
      cc_i_q  <= 1'b0;
      cc_j_q  <= 1'b0;
      cc_k_q  <= 1'b0;
      pos_i_q <= '0;
      pos_j_q <= '0;
      pos_k_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (gr3d_reg_e'(cfg_idx_i))
          REG_EXTENT_I: ext_i_q <= cfg_wdata_i;
          REG_EXTENT_J: ext_j_q <= cfg_wdata_i;
          REG_EXTENT_K: ext_k_q <= cfg_wdata_i;
          REG_CELL_I:   cc_i_q  <= cfg_wdata_i[0];
          REG_CELL_J:   cc_j_q  <= cfg_wdata_i[0];
          REG_CELL_K:   cc_k_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (restart) begin
        pos_i_q <= '0;
        pos_j_q <= '0;
        pos_k_q <= '0;
      end else begin
        pos_i_q <= pos_i_d;
        pos_j_q <= pos_j_d;
        pos_k_q <= pos_k_d;
      end
    end
  end

endmodule

// File: src/gr3d_queue.sv
`timescale 1ns / 1ps
module gr3d_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);
  `include "grid_restrict_3d_factor2_core_macros.svh"

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
    end
  end

  `GR3D_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
  `GR3D_ASSERT(a_no_push_full, push_i |-> !full_o, "push into a full queue")
  `GR3D_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from an empty queue")
  `GR3D_ASSERT_NEXT(a_push_count, push_i && !pop_i,
                    count_q == $past(count_q) + CNT_W'(1), "push did not raise count")

endmodule

// File: src/gr3d_back.sv
`timescale 1ns / 1ps
module gr3d_back #(
  parameter int MAX_EXTENT  = 256,
  parameter int SAMPLE_BITS = 32,
  localparam int CI_W = $clog2(MAX_EXTENT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  output logic                                pop_o,
  input  gr3d_pkg::gr3d_ctrl_t                ctrl_i,
  input  logic [CI_W-1:0]                     ci_i,
  input  logic [CI_W-1:0]                     cj_i,
  input  logic [CI_W-1:0]                     ck_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       coarse_value_o,
  output logic [gr3d_pkg::IDX_W-1:0]          coarse_i_o,
  output logic [gr3d_pkg::IDX_W-1:0]          coarse_j_o,
  output logic [gr3d_pkg::IDX_W-1:0]          coarse_k_o,
  output logic                                region_done_o
);
  import gr3d_pkg::*;
  `include "grid_restrict_3d_factor2_core_macros.svh"

  localparam int PS_W      = SAMPLE_BITS + 1;   // pair sum along i
  localparam int RS_W      = SAMPLE_BITS + 2;   // row sum over j
  localparam int QS_W      = SAMPLE_BITS + 3;   // plane sum over k
  localparam int PL_DEPTH  = MAX_EXTENT * MAX_EXTENT;
  localparam int PA_W      = $clog2(PL_DEPTH);

  logic                    adv;

  // Stage A (queue head)
  logic signed [PS_W-1:0]  pair_q, pair_d, sample_ext;
  logic [PA_W-1:0]         pidx_d;

  // Stage B
  logic                    b_valid_q;
  gr3d_ctrl_t              b_ctrl_q;
  logic [CI_W-1:0]         b_ci_q, b_cj_q, b_ck_q;
  logic [PA_W-1:0]         b_pidx_q;
  logic signed [PS_W-1:0]  b_pair_q;
  logic signed [RS_W-1:0]  row_mem [MAX_EXTENT];
  logic signed [RS_W-1:0]  row_rd_q, row_fwd_val_q, row_in, row_sum, pair_ext;
  logic                    row_fwd_q, row_we;

  // Stage C
  logic                    c_valid_q;
  gr3d_ctrl_t              c_ctrl_q;
  logic [CI_W-1:0]         c_ci_q, c_cj_q, c_ck_q;
  logic [PA_W-1:0]         c_pidx_q;
  logic signed [RS_W-1:0]  c_row_q;
  logic signed [QS_W-1:0]  plane_mem [PL_DEPTH];
  logic signed [QS_W-1:0]  plane_rd_q, plane_fwd_val_q, plane_in, plane_sum, row_ext;
  logic signed [QS_W-1:0]  shifted;
  logic                    plane_fwd_q, plane_we;

  // Output register
  logic                    out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [IDX_W-1:0]        out_ci_q, out_cj_q, out_ck_q;
  logic                    out_done_q;

  // Whole pipe moves together unless a result is stuck at the output
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  // Stage A: pair sum along i, plane address
  assign sample_ext = {sample_i[SAMPLE_BITS-1], sample_i};
  assign pair_d     = ctrl_i.odd_i ? pair_q + sample_ext : sample_ext;
  assign pidx_d     = PA_W'(cj_i) * PA_W'(MAX_EXTENT) + PA_W'(ci_i);

  // Stage B: row accumulate, bypass when the previous transaction wrote the same entry
  assign row_in   = row_fwd_q ? row_fwd_val_q : row_rd_q;
  assign pair_ext = {b_pair_q[PS_W-1], b_pair_q};
  assign row_sum  = b_ctrl_q.odd_j ? row_in + pair_ext : pair_ext;
  assign row_we   = adv && b_valid_q && b_ctrl_q.last_i;

  // Stage C: plane accumulate and floor division by the cell count
  assign plane_in  = plane_fwd_q ? plane_fwd_val_q : plane_rd_q;
  assign row_ext   = {c_row_q[RS_W-1], c_row_q};
  assign plane_sum = c_ctrl_q.odd_k ? plane_in + row_ext : row_ext;
  assign plane_we  = adv && c_valid_q;
  assign shifted   = plane_sum >>> c_ctrl_q.shift;

  // Row buffer
  always_ff @(posedge clk_i) begin
    if (adv) row_rd_q <= row_mem[ci_i];
    if (row_we) row_mem[b_ci_q] <= row_sum;
  end

  // Plane buffer
  always_ff @(posedge clk_i) begin
    if (adv) plane_rd_q <= plane_mem[b_pidx_q];
    if (plane_we) plane_mem[c_pidx_q] <= plane_sum;
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_o) pair_q <= pair_d;
      b_ctrl_q        <= ctrl_i;
      b_ci_q          <= ci_i;
      b_cj_q          <= cj_i;
      b_ck_q          <= ck_i;
      b_pidx_q        <= pidx_d;
      b_pair_q        <= pair_d;
      row_fwd_val_q   <= row_sum;
      c_ctrl_q        <= b_ctrl_q;
      c_ci_q          <= b_ci_q;
      c_cj_q          <= b_cj_q;
      c_ck_q          <= b_ck_q;
      c_pidx_q        <= b_pidx_q;
      c_row_q         <= row_sum;
      plane_fwd_val_q <= plane_sum;
      if (c_valid_q && c_ctrl_q.last_k) begin
        out_value_q <= shifted[SAMPLE_BITS-1:0];
        out_ci_q    <= IDX_W'(c_ci_q);
        out_cj_q    <= IDX_W'(c_cj_q);
        out_ck_q    <= IDX_W'(c_ck_q);
        out_done_q  <= c_ctrl_q.done;
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      row_fwd_q   <= 1'b0;
      plane_fwd_q <= 1'b0;
    end else if (adv) begin
      b_valid_q   <= pop_o;
      c_valid_q   <= b_valid_q && b_ctrl_q.last_i && b_ctrl_q.last_j;
      out_valid_q <= c_valid_q && c_ctrl_q.last_k;
      row_fwd_q   <= row_we && (b_ci_q == ci_i);
      plane_fwd_q <= plane_we && (c_pidx_q == b_pidx_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coarse_value_o = out_value_q;
  assign coarse_i_o     = out_ci_q;
  assign coarse_j_o     = out_cj_q;
  assign coarse_k_o     = out_ck_q;
  assign region_done_o  = out_done_q;

  `GR3D_ASSERT_NEXT(a_stall_holds, !adv,
                    $stable(b_valid_q) && $stable(c_valid_q), "pipe moved during stall")
  `GR3D_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(c_valid_q),
               "result appeared without a stage C transaction")
  `GR3D_ASSERT_NEXT(a_result_issued, adv && c_valid_q && c_ctrl_q.last_k, out_valid_q,
                    "finished group did not reach the output")

endmodule
